// ===== src/kti_pkg.sv =====
package kti_pkg;

   localparam int MAX_KEYS_DEFAULT = 64;
   localparam int KEY_IDX_W        = 6;
   localparam int WORD_W           = 32;
   localparam int COUNT_W          = 7;
   localparam int FRAC_W           = 16;
   localparam int PROD_W           = WORD_W + FRAC_W + 2;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_T0,
      ST_TL,
      ST_CHKL,
      ST_MOD,
      ST_SA,
      ST_SB,
      ST_SC,
      ST_F1,
      ST_F2,
      ST_F3,
      ST_F4,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } kti_state_type;

   typedef struct packed {
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } kti_entry_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } kti_div_status_type;

endpackage

// ===== src/kti_req_if.sv =====
interface kti_req_if;
   import kti_pkg::*;

   logic                        valid;
   logic                        ready;
   logic                        mode;
   logic [KEY_IDX_W-1:0]        key_index;
   logic [WORD_W-1:0]           key_time;
   logic signed [WORD_W-1:0]    key_x;
   logic signed [WORD_W-1:0]    key_y;
   logic signed [WORD_W-1:0]    key_z;
   logic [WORD_W-1:0]           query_time;

   modport source (output valid, mode, key_index, key_time, key_x, key_y, key_z,
                   query_time, input ready);
   modport sink (input valid, mode, key_index, key_time, key_x, key_y, key_z,
                 query_time, output ready);
endinterface

// ===== src/kti_rsp_if.sv =====
interface kti_rsp_if;
   import kti_pkg::*;

   logic                        valid;
   logic                        ready;
   logic signed [WORD_W-1:0]    out_x;
   logic signed [WORD_W-1:0]    out_y;
   logic signed [WORD_W-1:0]    out_z;
   logic [KEY_IDX_W-1:0]        segment;

   modport source (output valid, out_x, out_y, out_z, segment, input ready);
   modport sink (input valid, out_x, out_y, out_z, segment, output ready);
endinterface

// ===== src/kti_store.sv =====
module kti_store #(
   parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_KEYS)-1:0]   wr_addr,
   input  kti_pkg::kti_entry_type        wr_data,
   input  logic [$clog2(MAX_KEYS)-1:0]   rd_addr,
   output kti_pkg::kti_entry_type        rd_data
);
   import kti_pkg::*;

   kti_entry_type mem [MAX_KEYS];
   kti_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/kti_divider.sv =====
module kti_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [kti_pkg::WORD_W-1:0]    dividend,
   input  logic [kti_pkg::WORD_W-1:0]    divisor,
   output kti_pkg::kti_div_status_type   status
);
   import kti_pkg::*;

   localparam int CNT_W = $clog2(FRAC_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic [FRAC_W-1:0] quot_ff, quot_in;
   logic [WORD_W:0]   shifted;
   logic              fits;

   // The running remainder stays below the divisor, so one compare and
   // subtract gives each quotient bit.
   always_comb begin
      shifted = {rem_ff, 1'b0};
      fits    = shifted >= {1'b0, div_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in  = fits ? WORD_W'(shifted - {1'b0, div_ff}) : shifted[WORD_W-1:0];
         quot_in = {quot_ff[FRAC_W-2:0], fits};
         cnt_in  = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.quot = quot_ff;
endmodule

// ===== src/keyframe_track_interpolator.sv =====
// A key write is taken in the idle state and gives no item on the result side.
// A query's run time grows with the key count and with the wrap of a stale
// search start; it is set by one memory read per step of the segment walk,
// the serial divider and one shared multiplier.
// One item is worked on at a time. Reset (synchronous) sets the key count to
// one and the search start to zero; the key memory is not cleared.
module keyframe_track_interpolator #(
   parameter int MAX_KEYS = kti_pkg::MAX_KEYS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   kti_req_if.sink                       req_chan,
   kti_rsp_if.source                     rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [kti_pkg::COUNT_W-1:0]   csr_wr_data
);
   import kti_pkg::*;

   localparam int IW = $clog2(MAX_KEYS);
   localparam int NW = $clog2(MAX_KEYS + 1);

   kti_state_type      state_ff, state_in;
   logic [COUNT_W-1:0] keys_ff;
   logic [IW-1:0]      sstart_ff;
   logic [WORD_W-1:0]  q_ff;
   logic [NW-1:0]      n_ff;
   logic [IW-1:0]      a_ff;
   logic [NW-1:0]      rem_ff;
   logic [WORD_W-1:0]  ta_ff;
   logic [IW-1:0]      k_ff;
   kti_entry_type      e1_ff, e2_ff;
   logic [FRAC_W-1:0]  f_ff;
   logic [1:0]         comp_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [WORD_W-1:0]  ox_ff, oy_ff, oz_ff;
   logic               rsp_valid_ff;
   logic [WORD_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic [KEY_IDX_W-1:0] rsp_seg_ff;

   logic               req_fire;
   logic [NW-1:0]      n_eff;
   logic [IW-1:0]      last_idx;
   logic [IW-1:0]      end_idx;
   logic [IW-1:0]      rd_addr;
   logic               wr_en;
   logic               div_start;
   logic               out_free;
   logic               seg_hit;
   logic               take_end, take_start;
   kti_entry_type      rd_data, wr_data;
   kti_div_status_type div_status;
   logic [WORD_W-1:0]  p1, p2;
   logic signed [WORD_W:0]     diff;
   logic signed [PROD_W-1:0]   mult;
   logic [WORD_W-1:0]  blended;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign last_idx = IW'(n_ff - NW'(1));
   assign end_idx  = ((NW'(k_ff) + NW'(1)) < n_ff) ? IW'(k_ff + IW'(1)) : k_ff;
   assign seg_hit  = (ta_ff <= q_ff) && (q_ff <= rd_data.t);
   assign take_end   = (e2_ff.t == e1_ff.t) || (q_ff >= e2_ff.t);
   assign take_start = q_ff <= e1_ff.t;

   always_comb begin
      if (keys_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(keys_ff) > 32'(MAX_KEYS)) begin
         n_eff = NW'(MAX_KEYS);
      end else begin
         n_eff = NW'(keys_ff);
      end
   end

   assign wr_data.t = req_chan.key_time;
   assign wr_data.x = req_chan.key_x;
   assign wr_data.y = req_chan.key_y;
   assign wr_data.z = req_chan.key_z;

   kti_store #(.MAX_KEYS(MAX_KEYS)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(req_chan.key_index)),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kti_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (q_ff - e1_ff.t),
      .divisor  (e2_ff.t - e1_ff.t),
      .status   (div_status)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_fire && req_chan.mode == MODE_QUERY) state_in = ST_T0;
         ST_T0:   state_in = ST_TL;
         ST_TL:   state_in = (q_ff <= rd_data.t) ? ST_F1 : ST_CHKL;
         ST_CHKL: state_in = (q_ff >= rd_data.t) ? ST_F1 : ST_MOD;
         ST_MOD:  if (NW'(a_ff) < n_ff) state_in = ST_SA;
         ST_SA: begin
            if (a_ff != last_idx) begin
               state_in = ST_SB;
            end else if (rem_ff == NW'(1)) begin
               state_in = ST_F1;
            end
         end
         ST_SB:   state_in = ST_SC;
         ST_SC: begin
            if (seg_hit || rem_ff == NW'(1)) begin
               state_in = ST_F1;
            end else if (IW'(a_ff + IW'(1)) == last_idx) begin
               state_in = (rem_ff == NW'(2)) ? ST_F1 : ST_SA;
            end
         end
         ST_F1:   state_in = ST_F2;
         ST_F2:   state_in = ST_F3;
         ST_F3:   state_in = ST_F4;
         ST_F4:   state_in = (take_end || take_start) ? ST_DONE : ST_DIV;
         ST_DIV:  if (div_status.done) state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  if (comp_ff == 2'd2) state_in = ST_DONE;
                  else state_in = ST_MUL;
         ST_DONE: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      rd_addr        = a_ff;
      wr_en          = 1'b0;
      div_start      = 1'b0;
      req_chan.ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            wr_en = req_chan.valid && req_chan.mode == MODE_WRITE &&
                    32'(req_chan.key_index) < 32'(MAX_KEYS);
         end
         ST_T0:   rd_addr = '0;
         ST_TL:   rd_addr = last_idx;
         ST_SB:   rd_addr = IW'(a_ff + IW'(1));
         ST_SC:   rd_addr = IW'(a_ff + IW'(2));
         ST_F1:   rd_addr = k_ff;
         ST_F2:   rd_addr = end_idx;
         ST_F4:   div_start = !(take_end || take_start);
         default: rd_addr = a_ff;
      endcase
   end

   // Shared blend unit: one multiply, then the add of the start value.
   always_comb begin
      case (comp_ff)
         2'd0: begin p1 = e1_ff.x; p2 = e2_ff.x; end
         2'd1: begin p1 = e1_ff.y; p2 = e2_ff.y; end
         default: begin p1 = e1_ff.z; p2 = e2_ff.z; end
      endcase
      diff    = $signed({p2[WORD_W-1], p2}) - $signed({p1[WORD_W-1], p1});
      mult    = diff * $signed({1'b0, f_ff});
      // An arithmetic shift floors, which matches rounding half up.
      blended = p1 + WORD_W'(prod_ff >>> FRAC_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keys_ff      <= COUNT_W'(1);
         sstart_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            keys_ff <= csr_wr_data;
         end
         if (state_ff == ST_F1) begin
            sstart_ff <= k_ff;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            q_ff <= req_chan.query_time;
            n_ff <= n_eff;
         end
         ST_TL: k_ff <= '0;
         ST_CHKL: begin
            k_ff   <= last_idx;
            a_ff   <= sstart_ff;
            rem_ff <= n_ff - NW'(1);
         end
         ST_MOD: if (NW'(a_ff) >= n_ff) a_ff <= IW'(NW'(a_ff) - n_ff);
         ST_SA: begin
            // The wrap segment can never hold a time below the last key.
            if (a_ff == last_idx) begin
               a_ff   <= '0;
               rem_ff <= rem_ff - NW'(1);
            end
         end
         ST_SB: ta_ff <= rd_data.t;
         ST_SC: begin
            if (seg_hit) begin
               k_ff <= a_ff;
            end else if (IW'(a_ff + IW'(1)) == last_idx) begin
               a_ff   <= '0;
               rem_ff <= rem_ff - NW'(2);
            end else begin
               a_ff   <= IW'(a_ff + IW'(1));
               rem_ff <= rem_ff - NW'(1);
               ta_ff  <= rd_data.t;
            end
         end
         ST_F2: e1_ff <= rd_data;
         ST_F3: e2_ff <= rd_data;
         ST_F4: begin
            if (take_end) begin
               ox_ff <= e2_ff.x;
               oy_ff <= e2_ff.y;
               oz_ff <= e2_ff.z;
            end else if (take_start) begin
               ox_ff <= e1_ff.x;
               oy_ff <= e1_ff.y;
               oz_ff <= e1_ff.z;
            end
            comp_ff <= 2'd0;
         end
         ST_DIV:  f_ff <= div_status.quot;
         ST_MUL:  prod_ff <= mult + PROD_W'(32768);
         ST_ADD: begin
            case (comp_ff)
               2'd0:    ox_ff <= blended;
               2'd1:    oy_ff <= blended;
               default: oz_ff <= blended;
            endcase
            comp_ff <= comp_ff + 2'd1;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_x_ff   <= ox_ff;
               rsp_y_ff   <= oy_ff;
               rsp_z_ff   <= oz_ff;
               rsp_seg_ff <= KEY_IDX_W'(k_ff);
            end
         end
         default: ;
      endcase
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.out_x   = rsp_x_ff;
   assign rsp_chan.out_y   = rsp_y_ff;
   assign rsp_chan.out_z   = rsp_z_ff;
   assign rsp_chan.segment = rsp_seg_ff;

`ifndef SYNTHESIS
   a_walk_has_segments: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SC) |-> (rem_ff != '0))
      else $error("segment walk running with no segments left");
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside the divide step");
   a_query_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.mode == MODE_QUERY) |=> (state_ff == ST_T0))
      else $error("accepted query did not start the bound check");
   a_segment_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_F1) |-> (NW'(k_ff) < n_ff))
      else $error("chosen segment beyond the key count");
`endif
endmodule

// ===== dv/tb_keyframe_track_interpolator.sv =====
`timescale 1ns / 100ps

module tb_keyframe_track_interpolator;
   import kti_pkg::*;

   localparam int KEYS        = MAX_KEYS_DEFAULT;
   localparam int STALL_LIMIT = 4000;
   localparam int LONG_HOLD   = 600;
   localparam int SETTLE      = 200;

   typedef struct {
      logic        mode;
      logic [5:0]  idx;
      logic [31:0] kt;
      logic [31:0] kx;
      logic [31:0] ky;
      logic [31:0] kz;
      logic [31:0] qt;
   } kf_item_type;

   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [5:0]  seg;
   } sample_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   kti_req_if req_if ();
   kti_rsp_if rsp_if ();

   keyframe_track_interpolator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   kf_item_type pending[$];
   sample_type  samples_due[$];
   kf_item_type drv_item;

   // Track as seen by the predictor, updated on accepted items only.
   logic [31:0] trk_time [KEYS];
   logic [31:0] trk_x [KEYS];
   logic [31:0] trk_y [KEYS];
   logic [31:0] trk_z [KEYS];
   int unsigned seg_cache;
   int unsigned n_keys_cfg;

   // Times as planned by the stimulus, ahead of acceptance.
   logic [31:0] plan_time [KEYS];

   int snd_idle;
   int rsp_idle;
   int hold_cnt;
   int stall_cnt;
   int n_errors;
   int n_queries;
   int n_writes;
   int n_samples;

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [31:0] lerp_word(logic [31:0] a, logic [31:0] b, logic [63:0] f);
      longint pa;
      longint pr;
      pa = longint'($signed(a));
      pr = (longint'($signed(b)) - pa) * longint'(f) + 64'sd32768;
      // An arithmetic shift floors, which gives rounding half up on both signs.
      return 32'(pa + (pr >>> 16));
   endfunction

   function automatic void track_model(kf_item_type it);
      int unsigned n, k, s, a, b, e;
      logic [31:0] t1, t2;
      logic [63:0] f;
      bit          hit;
      sample_type  r;
      if (it.mode == MODE_WRITE) begin
         trk_time[it.idx] = it.kt;
         trk_x[it.idx] = it.kx;
         trk_y[it.idx] = it.ky;
         trk_z[it.idx] = it.kz;
         return;
      end
      n = n_keys_cfg;
      if (n == 0) n = 1;
      if (n > KEYS) n = KEYS;
      if (it.qt <= trk_time[0]) begin
         k = 0;
      end else if (it.qt >= trk_time[n-1]) begin
         k = n - 1;
      end else begin
         k = n - 1;
         s = seg_cache % n;
         hit = 1'b0;
         for (int j = 0; j + 1 < n; j++) begin
            a = (s + j) % n;
            b = (a + 1 < n) ? a + 1 : a;
            if (!hit && trk_time[a] <= it.qt && it.qt <= trk_time[b]) begin
               k = a;
               hit = 1'b1;
            end
         end
      end
      seg_cache = k;
      e = (k + 1 < n) ? k + 1 : k;
      t1 = trk_time[k];
      t2 = trk_time[e];
      if (t2 == t1 || it.qt >= t2) begin
         r.x = trk_x[e];
         r.y = trk_y[e];
         r.z = trk_z[e];
      end else if (it.qt <= t1) begin
         r.x = trk_x[k];
         r.y = trk_y[k];
         r.z = trk_z[k];
      end else begin
         f = ({32'd0, it.qt - t1} << 16) / {32'd0, t2 - t1};
         r.x = lerp_word(trk_x[k], trk_x[e], f);
         r.y = lerp_word(trk_y[k], trk_y[e], f);
         r.z = lerp_word(trk_z[k], trk_z[e], f);
      end
      r.seg = k[5:0];
      samples_due.push_back(r);
   endfunction

   // Sender.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (pending.size() > 0 && $urandom_range(99) >= snd_idle) begin
            drv_item = pending.pop_front();
            req_if.valid <= 1'b1;
            req_if.mode <= drv_item.mode;
            req_if.key_index <= drv_item.idx;
            req_if.key_time <= drv_item.kt;
            req_if.key_x <= drv_item.kx;
            req_if.key_y <= drv_item.ky;
            req_if.key_z <= drv_item.kz;
            req_if.query_time <= drv_item.qt;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Prediction on every accepted item.
   always @(posedge clock) begin
      kf_item_type acc;
      if (!reset && req_if.valid && req_if.ready) begin
         acc.mode = req_if.mode;
         acc.idx = req_if.key_index;
         acc.kt = req_if.key_time;
         acc.kx = req_if.key_x;
         acc.ky = req_if.key_y;
         acc.kz = req_if.key_z;
         acc.qt = req_if.query_time;
         track_model(acc);
      end
   end

   // Receiver and checker.
   always @(posedge clock) begin
      sample_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            n_samples <= n_samples + 1;
            if (samples_due.size() == 0) begin
               $error("result with nothing expected: x %h seg %0d", rsp_if.out_x,
                      rsp_if.segment);
               n_errors = n_errors + 1;
            end else begin
               want = samples_due.pop_front();
               if (rsp_if.out_x !== want.x) begin
                  $error("out_x expected %h got %h", want.x, rsp_if.out_x);
                  n_errors = n_errors + 1;
               end
               if (rsp_if.out_y !== want.y) begin
                  $error("out_y expected %h got %h", want.y, rsp_if.out_y);
                  n_errors = n_errors + 1;
               end
               if (rsp_if.out_z !== want.z) begin
                  $error("out_z expected %h got %h", want.z, rsp_if.out_z);
                  n_errors = n_errors + 1;
               end
               if (rsp_if.segment !== want.seg) begin
                  $error("segment expected %0d got %0d", want.seg, rsp_if.segment);
                  n_errors = n_errors + 1;
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cnt <= 0;
      end else begin
         stall_cnt <= stall_cnt + 1;
         if (stall_cnt == STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic push_key(int idx, logic [31:0] t, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
      kf_item_type it;
      it.mode = MODE_WRITE;
      it.idx = idx[5:0];
      it.kt = t;
      it.kx = x;
      it.ky = y;
      it.kz = z;
      it.qt = $urandom;
      plan_time[idx] = t;
      pending.push_back(it);
      n_writes++;
   endtask

   task automatic push_query(logic [31:0] q);
      kf_item_type it;
      it.mode = MODE_QUERY;
      it.idx = 6'($urandom);
      it.kt = $urandom;
      it.kx = $urandom;
      it.ky = $urandom;
      it.kz = $urandom;
      it.qt = q;
      pending.push_back(it);
      n_queries++;
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending.size() > 0 || samples_due.size() > 0 || req_if.valid);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_key_count(int unsigned v);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      n_keys_cfg = v & 7'h7F;
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Writes keys 0..n-1; when ordered, in ascending time with some repeated times, else at random times.
   task automatic load_track(int n, bit ordered);
      logic [63:0] acc;
      acc = 64'($urandom_range(0, 32'h0100_0000));
      for (int i = 0; i < n; i++) begin
         if (!ordered) begin
            acc = 64'($urandom);
         end else if (i > 0 && $urandom_range(5) != 0) begin
            acc = acc + 64'($urandom_range(1, 1 << $urandom_range(0, 26)));
            if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
         end
         push_key(i, acc[31:0], rand_value(), rand_value(), rand_value());
      end
   endtask

   task automatic query_track(int n, int count);
      int k;
      logic [31:0] lo, hi;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, n - 1);
         lo = plan_time[k];
         hi = plan_time[(k + 1 < n) ? k + 1 : k];
         case ($urandom_range(7))
            0: push_query($urandom_range(0, plan_time[0]));
            1: push_query($urandom_range(plan_time[n-1], 32'hFFFF_FFFF));
            2: push_query(lo);
            3: push_query($urandom);
            default: push_query($urandom_range(lo, hi));
         endcase
      end
   endtask

   initial begin
      int unsigned cfg;
      int eff;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.mode = MODE_WRITE;
      req_if.key_index = '0;
      req_if.key_time = '0;
      req_if.key_x = '0;
      req_if.key_y = '0;
      req_if.key_z = '0;
      req_if.query_time = '0;
      rsp_if.ready = 1'b0;
      seg_cache = 0;
      n_keys_cfg = 1;
      snd_idle = 0;
      rsp_idle = 0;
      hold_cnt = 0;
      stall_cnt = 0;
      n_errors = 0;
      n_queries = 0;
      n_writes = 0;
      n_samples = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every slot is written once up front, so no query ever reads an empty entry.
      load_track(KEYS, 1'b1);

      // Directed: extreme values, clamping at both ends and a zero-length segment.
      set_key_count(4);
      push_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
      push_key(1, 32'h0002_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_key(2, 32'h0002_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      push_key(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      push_query(32'h0000_0000);
      push_query(32'h0001_0000);
      push_query(32'h0001_8000);
      push_query(32'h0001_0001);
      push_query(32'h0001_FFFF);
      push_query(32'h0002_0000);
      push_query(32'h8000_0000);
      push_query(32'hFFFF_FFFE);
      push_query(32'hFFFF_FFFF);
      wait_idle();

      for (int ph = 0; ph < 3; ph++) begin
         snd_idle = (ph == 0) ? 15 : (ph == 1) ? 52 : 0;
         rsp_idle = (ph == 0) ? 52 : (ph == 1) ? 15 : 0;
         for (int r = 0; r < 6; r++) begin
            if (ph == 0 && r == 0) cfg = 0;
            else if (ph == 0 && r == 1) cfg = 127;
            else if (ph == 1 && r == 0) cfg = KEYS;
            else begin
               case ($urandom_range(9))
                  0: cfg = $urandom_range(KEYS + 1, 127);
                  1: cfg = 1;
                  2: cfg = 2;
                  3: cfg = $urandom_range(17, KEYS);
                  default: cfg = $urandom_range(2, 16);
               endcase
            end
            set_key_count(cfg);
            eff = (cfg == 0) ? 1 : (cfg > KEYS) ? KEYS : cfg;
            if (ph == 0 && r == 2) hold_cnt = LONG_HOLD;
            // Most rounds reload the track; some keep the old one to age the search start.
            if ($urandom_range(3) != 0) load_track(eff, $urandom_range(7) != 0);
            query_track(eff, 44);
         end
      end

      wait_idle();
      $display("covered %0d key writes and %0d queries, %0d results checked",
               n_writes, n_queries, n_samples);
      $display("key counts from zero to saturation, three handshake pacing schemes");
      if (n_errors == 0 && samples_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
